>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the stanza tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge out of reset.
`define SFT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define SFT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sft_pkg.sv
// ----------------------------------------------------------------------------
// sft_pkg
// Shared types, character codes and helpers for the stanza field tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sft_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int RES_W             = 32;

  localparam int Q_DEPTH = 4;
  localparam int Q_IDX_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SUB    = 8'h1A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  typedef enum logic [3:0] {
    PH_BETWEEN,
    PH_NAME,
    PH_PRECOLON,
    PH_AFTERCOLON,
    PH_VALUE,
    PH_EOL,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    EVT_FIELD,
    EVT_STANZA,
    EVT_ERROR
  } evt_kind_t;

  typedef enum logic [3:0] {
    ERR_EMPTY_NAME,
    ERR_LEAD_HYPHEN,
    ERR_EOF_NAME,
    ERR_NL_NAME,
    ERR_SUB_NAME,
    ERR_NO_COLON,
    ERR_EOF_PREVALUE,
    ERR_SUB_VALUE,
    ERR_BLANK_CONT,
    ERR_EOF_VALUE
  } err_code_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } sft_item_t;

  typedef struct packed {
    evt_kind_t        event_kind;
    logic [RES_W-1:0] name_start;
    logic [RES_W-1:0] name_length;
    logic [RES_W-1:0] value_start;
    logic [RES_W-1:0] value_length;
    err_code_t        error_code;
    logic [RES_W-1:0] line_number;
    logic             last;
  } sft_result_t;

  typedef struct packed {
    logic [1:0]  count;
    sft_result_t first;
    sft_result_t second;
  } sft_push_t;

  function automatic sft_result_t make_result(
    input evt_kind_t        kind,
    input logic [RES_W-1:0] ns,
    input logic [RES_W-1:0] nl,
    input logic [RES_W-1:0] vs,
    input logic [RES_W-1:0] vl,
    input err_code_t        err,
    input logic [RES_W-1:0] ln
  );
    sft_result_t r;
    r.event_kind   = kind;
    r.name_start   = ns;
    r.name_length  = nl;
    r.value_start  = vs;
    r.value_length = vl;
    r.error_code   = err;
    r.line_number  = ln;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/stanza_field_tokenizer.sv
// ----------------------------------------------------------------------------
// stanza_field_tokenizer
// Splits a byte stream into stanzas of name: value fields and reports field,
// stanza-end and syntax-error events with offsets, lengths and line count.
// ----------------------------------------------------------------------------
//  channel | signals                         | carries
//  --------+---------------------------------+------------------------------
//  item    | item_valid, item_stall, item    | one byte or end of data
//  evt     | evt_valid, evt_stall, evt       | one event per beat
//
//  One item beat per cycle while item_stall is low. A beat yields zero to two
//  events; a four-entry queue drains one per cycle while evt_stall is low.
//  item_stall rises when the queue would hold more than two events after
//  this cycle's pop, so bursts of two-event beats run below one per cycle.
//  rst is synchronous, active high, and clears parse state and the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stanza_field_tokenizer #(
  parameter int POSITION_BITS = sft_pkg::POSITION_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire sft_pkg::sft_item_t   item,
  output logic                      evt_valid,
  input  wire logic                 evt_stall,
  output sft_pkg::sft_result_t      evt
);

  logic               take;
  logic               room;
  sft_pkg::sft_push_t push;

  assign item_stall = !room;
  assign take       = item_valid && room;

  sft_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (item),
    .push (push)
  );

  sft_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (take),
    .push      (push),
    .room      (room),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

endmodule

`default_nettype wire

>>> rtl/core/sft_parser.sv
// ----------------------------------------------------------------------------
// sft_parser
// Parse state registers and the per-beat next-state / event logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sft_parser #(
  parameter int POSITION_BITS = sft_pkg::POSITION_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire sft_pkg::sft_item_t item,
  output sft_pkg::sft_push_t     push
);

  localparam int PW = POSITION_BITS;
  localparam int RW = sft_pkg::RES_W;

  sft_pkg::phase_t phase, phase_next;
  logic [PW-1:0]   pos, pos_next;
  logic [RW-1:0]   line_cnt, line_cnt_next;
  logic [PW-1:0]   name_start, name_start_next;
  logic [PW-1:0]   name_len, name_len_next;
  logic [PW-1:0]   value_start, value_start_next;
  logic [PW-1:0]   value_end, value_end_next;
  logic            blank, blank_next;
  logic            hyphen, hyphen_next;

  logic [7:0]         c;
  logic               c_ws;
  logic               c_term;
  logic               start_name;
  logic               f_field;
  logic               f_err;
  logic               f_stanza;
  sft_pkg::err_code_t err;

  sft_pkg::sft_result_t rec_field;
  sft_pkg::sft_result_t rec_err;
  sft_pkg::sft_result_t rec_stanza;
  logic [PW-1:0]        err_ns;
  logic [PW-1:0]        err_nl;
  logic [PW-1:0]        value_len;
  logic [RW-1:0]        stanza_ln;

  assign c      = item.data_byte;
  assign c_ws   = (c == sft_pkg::CH_SPACE) ||
                  (c >= sft_pkg::CH_TAB && c <= sft_pkg::CH_CR);
  assign c_term = (c == sft_pkg::CH_NL) || (c == sft_pkg::CH_SUB);

  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    line_cnt_next    = line_cnt;
    name_start_next  = name_start;
    name_len_next    = name_len;
    value_start_next = value_start;
    value_end_next   = value_end;
    blank_next       = blank;
    hyphen_next      = hyphen;
    start_name       = 1'b0;
    f_field          = 1'b0;
    f_err            = 1'b0;
    f_stanza         = 1'b0;
    err              = sft_pkg::ERR_EMPTY_NAME;

    if (item.end_of_data) begin
      unique case (phase)
        sft_pkg::PH_NAME: begin
          f_err = 1'b1;
          err   = hyphen ? sft_pkg::ERR_LEAD_HYPHEN : sft_pkg::ERR_EOF_NAME;
        end
        sft_pkg::PH_PRECOLON: begin
          f_err = 1'b1;
          err   = sft_pkg::ERR_EOF_NAME;
        end
        sft_pkg::PH_AFTERCOLON: begin
          f_err = 1'b1;
          err   = sft_pkg::ERR_EOF_PREVALUE;
        end
        sft_pkg::PH_VALUE: begin
          f_err = 1'b1;
          err   = sft_pkg::ERR_EOF_VALUE;
        end
        sft_pkg::PH_EOL: begin
          f_field  = 1'b1;
          f_stanza = 1'b1;
        end
        default: ;
      endcase
      phase_next       = sft_pkg::PH_BETWEEN;
      pos_next         = '0;
      line_cnt_next    = '0;
      name_start_next  = '0;
      name_len_next    = '0;
      value_start_next = '0;
      value_end_next   = '0;
      blank_next       = 1'b0;
      hyphen_next      = 1'b0;
    end else begin
      unique case (phase)
        sft_pkg::PH_BETWEEN: begin
          if (c_term) begin
            line_cnt_next = line_cnt + RW'(1);
          end else begin
            start_name = 1'b1;
          end
        end
        sft_pkg::PH_NAME: begin
          priority if (!c_ws && c != sft_pkg::CH_COLON && c != sft_pkg::CH_SUB) begin
            name_len_next = name_len + PW'(1);
          end else if (hyphen) begin
            f_err = 1'b1;
            err   = sft_pkg::ERR_LEAD_HYPHEN;
          end else if (c == sft_pkg::CH_NL) begin
            f_err = 1'b1;
            err   = sft_pkg::ERR_NL_NAME;
          end else if (c == sft_pkg::CH_SUB) begin
            f_err = 1'b1;
            err   = sft_pkg::ERR_SUB_NAME;
          end else if (c == sft_pkg::CH_COLON) begin
            phase_next = sft_pkg::PH_AFTERCOLON;
          end else begin
            phase_next = sft_pkg::PH_PRECOLON;
          end
        end
        sft_pkg::PH_PRECOLON: begin
          priority if (c == sft_pkg::CH_NL) begin
            f_err = 1'b1;
            err   = sft_pkg::ERR_NL_NAME;
          end else if (c == sft_pkg::CH_SUB) begin
            f_err = 1'b1;
            err   = sft_pkg::ERR_SUB_NAME;
          end else if (c == sft_pkg::CH_COLON) begin
            phase_next = sft_pkg::PH_AFTERCOLON;
          end else if (!c_ws) begin
            f_err = 1'b1;
            err   = sft_pkg::ERR_NO_COLON;
          end else begin
            phase_next = phase;
          end
        end
        sft_pkg::PH_AFTERCOLON: begin
          priority if (c != sft_pkg::CH_NL && c_ws) begin
            phase_next = phase;
          end else if (c == sft_pkg::CH_SUB) begin
            f_err = 1'b1;
            err   = sft_pkg::ERR_SUB_VALUE;
          end else if (c == sft_pkg::CH_NL) begin
            value_start_next = pos;
            value_end_next   = pos;
            blank_next       = 1'b0;
            line_cnt_next    = line_cnt + RW'(1);
            phase_next       = sft_pkg::PH_EOL;
          end else begin
            value_start_next = pos;
            value_end_next   = pos + PW'(1);
            blank_next       = 1'b0;
            phase_next       = sft_pkg::PH_VALUE;
          end
        end
        sft_pkg::PH_VALUE: begin
          if (c_term) begin
            if (blank) begin
              f_err = 1'b1;
              err   = sft_pkg::ERR_BLANK_CONT;
            end else begin
              if (c == sft_pkg::CH_SUB) begin
                value_end_next = pos + PW'(1);
              end
              line_cnt_next = line_cnt + RW'(1);
              phase_next    = sft_pkg::PH_EOL;
            end
          end else if (!c_ws) begin
            value_end_next = pos + PW'(1);
            blank_next     = 1'b0;
          end
        end
        sft_pkg::PH_EOL: begin
          priority if (c == sft_pkg::CH_NL) begin
            f_field       = 1'b1;
            f_stanza      = 1'b1;
            line_cnt_next = line_cnt + RW'(1);
            phase_next    = sft_pkg::PH_BETWEEN;
          end else if (c == sft_pkg::CH_SUB) begin
            f_field    = 1'b1;
            f_stanza   = 1'b1;
            phase_next = sft_pkg::PH_BETWEEN;
          end else if (c_ws) begin
            blank_next = 1'b1;
            phase_next = sft_pkg::PH_VALUE;
          end else begin
            f_field    = 1'b1;
            start_name = 1'b1;
          end
        end
        default: ;
      endcase

      if (start_name) begin
        name_start_next = pos;
        if (c == sft_pkg::CH_COLON || c_ws) begin
          name_len_next = '0;
          f_err         = 1'b1;
          err           = sft_pkg::ERR_EMPTY_NAME;
        end else begin
          name_len_next = PW'(1);
          hyphen_next   = (c == sft_pkg::CH_HYPHEN);
          phase_next    = sft_pkg::PH_NAME;
        end
      end

      if (f_err) begin
        phase_next = sft_pkg::PH_ERROR;
      end
      pos_next = pos + PW'(1);
    end
  end

  // event records; errors see this beat's name, or the held one at end of data
  assign err_ns    = item.end_of_data ? name_start : name_start_next;
  assign err_nl    = item.end_of_data ? name_len : name_len_next;
  assign stanza_ln = item.end_of_data ? line_cnt : line_cnt_next;

  // length wraps at the position width before it is widened
  assign value_len = value_end - value_start;

  assign rec_field = sft_pkg::make_result(sft_pkg::EVT_FIELD, RW'(name_start),
                                          RW'(name_len), RW'(value_start),
                                          RW'(value_len),
                                          sft_pkg::ERR_EMPTY_NAME, line_cnt);
  assign rec_err = sft_pkg::make_result(sft_pkg::EVT_ERROR, RW'(err_ns), RW'(err_nl),
                                        '0, '0, err, line_cnt);
  assign rec_stanza = sft_pkg::make_result(sft_pkg::EVT_STANZA, '0, '0, '0, '0,
                                           sft_pkg::ERR_EMPTY_NAME, stanza_ln);

  always_comb begin
    push.count  = 2'(f_field) + 2'(f_err) + 2'(f_stanza);
    push.first  = f_field ? rec_field : (f_err ? rec_err : rec_stanza);
    push.second = f_err ? rec_err : rec_stanza;
    push.first.last  = (push.count == 2'd1);
    push.second.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= sft_pkg::PH_BETWEEN;
      pos         <= '0;
      line_cnt    <= '0;
      name_start  <= '0;
      name_len    <= '0;
      value_start <= '0;
      value_end   <= '0;
      blank       <= 1'b0;
      hyphen      <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      pos         <= pos_next;
      line_cnt    <= line_cnt_next;
      name_start  <= name_start_next;
      name_len    <= name_len_next;
      value_start <= value_start_next;
      value_end   <= value_end_next;
      blank       <= blank_next;
      hyphen      <= hyphen_next;
    end
  end

  `SFT_ASSERT_IMPL(a_error_silent, clk, rst,
    take && phase == sft_pkg::PH_ERROR, push.count == 2'd0,
    "events produced after a syntax error")
  `SFT_ASSERT_NEXT(a_eod_restart, clk, rst,
    take && item.end_of_data,
    phase == sft_pkg::PH_BETWEEN && pos == '0 && line_cnt == '0,
    "state not restarted after end of data")
  `SFT_ASSERT_IMPL(a_err_not_stanza, clk, rst,
    f_err, !f_stanza,
    "error and stanza end raised by one beat")

endmodule

`default_nettype wire

>>> rtl/core/sft_result_queue.sv
// ----------------------------------------------------------------------------
// sft_result_queue
// Small result queue: takes up to two events per beat, hands out one per
// cycle while evt_stall is low, and signals room for another input beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sft_result_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_en,
  input  wire sft_pkg::sft_push_t   push,
  output logic                      room,
  output logic                      evt_valid,
  input  wire logic                 evt_stall,
  output sft_pkg::sft_result_t      evt
);

  localparam int IW = sft_pkg::Q_IDX_W;
  localparam int CW = sft_pkg::Q_CNT_W;

  sft_pkg::sft_result_t slots [sft_pkg::Q_DEPTH];
  logic [IW-1:0]        head, head_next;
  logic [IW-1:0]        tail, tail_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        count_after_pop;
  logic [1:0]           n_push;
  logic                 pop;

  assign evt_valid       = (count != '0);
  assign evt             = slots[head];
  assign pop             = evt_valid && !evt_stall;
  assign count_after_pop = count - CW'(pop);
  assign room            = (count_after_pop <= CW'(sft_pkg::Q_DEPTH - 2));
  assign n_push          = push_en ? push.count : 2'd0;

  assign head_next  = head + IW'(pop);
  assign tail_next  = tail + IW'(n_push);
  assign count_next = count_after_pop + CW'(n_push);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      slots[tail] <= push.first;
    end
    if (n_push == 2'd2) begin
      slots[tail + IW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  `SFT_ASSERT(a_count_bound, clk, rst,
    count <= CW'(sft_pkg::Q_DEPTH),
    "queue count beyond depth")
  `SFT_ASSERT_IMPL(a_no_overflow, clk, rst,
    n_push != 2'd0, room,
    "events pushed without room")
  `SFT_ASSERT_NEXT(a_drain_empty, clk, rst,
    pop && count == CW'(1) && n_push == 2'd0, !evt_valid,
    "queue still valid after last event taken")

endmodule

`default_nettype wire
